/* src/slme_pkg.sv */
// Package for the single-linkage merge engine.
// Holds field widths, operation and state codes, and the result record.
// Used by every module in src; depends on nothing.
package slme_pkg;

  localparam int IDX_W             = 6;
  localparam int DIST_W            = 48;
  localparam int COUNT_W           = 7;
  localparam int MAX_ITEMS_DEFAULT = 64;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_FIND  = 2'd1,
    MODE_MERGE = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_MERGE,
    ST_MERGE_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   first_index;
    logic [IDX_W-1:0]   second_index;
    logic [DIST_W-1:0]  min_distance;
    logic [COUNT_W-1:0] active_count;
  } result_t;

endpackage

/* src/slme_dist_ram.sv */
// Distance store: one write port and two read ports, read data registered.
// Depends on slme_pkg for the distance width.
module slme_dist_ram #(
  parameter int AW = 12
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [slme_pkg::DIST_W-1:0] wdata,
  input  logic [AW-1:0]               raddr_a,
  input  logic [AW-1:0]               raddr_b,
  output logic [slme_pkg::DIST_W-1:0] rdata_a,
  output logic [slme_pkg::DIST_W-1:0] rdata_b
);
  import slme_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [DIST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* src/slme_ctrl.sv */
// Sequencer of the merge engine: active mask, count, pair scan and merge walk.
// Drives the distance store ports; depends on slme_pkg.
module slme_ctrl #(
  parameter int  MAX_ITEMS = slme_pkg::MAX_ITEMS_DEFAULT,
  localparam int IW        = $clog2(MAX_ITEMS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [slme_pkg::IDX_W-1:0]  row_index,
  input  logic [slme_pkg::IDX_W-1:0]  col_index,
  input  logic [slme_pkg::DIST_W-1:0] distance,
  output logic                        res_valid,
  input  logic                        res_ready,
  output slme_pkg::result_t           res,
  output logic                        we,
  output logic [2*IW-1:0]             waddr,
  output logic [slme_pkg::DIST_W-1:0] wdata,
  output logic [2*IW-1:0]             raddr_a,
  output logic [2*IW-1:0]             raddr_b,
  input  logic [slme_pkg::DIST_W-1:0] rdata_a,
  input  logic [slme_pkg::DIST_W-1:0] rdata_b
);
  import slme_pkg::*;

  function automatic logic [2*IW-1:0] pair_addr(logic [IW-1:0] a, logic [IW-1:0] b);
    logic [2*IW-1:0] addr;
    addr = (a > b) ? {a, b} : {b, a};
    return addr;
  endfunction

  state_t             state, state_next;
  logic [IW-1:0]      ri, ci;
  logic [DIST_W-1:0]  load_dist;
  logic [IW-1:0]      i, i_next, j, j_next;
  logic               pend_v, pend_v_next;
  logic [IW-1:0]      pend_a, pend_a_next, pend_b, pend_b_next;
  logic               best_found, best_found_next;
  logic [DIST_W-1:0]  best_d, best_d_next;
  logic [IW-1:0]      best_i, best_i_next, best_j, best_j_next;
  logic [MAX_ITEMS-1:0] active, active_next;
  logic [COUNT_W-1:0] count, count_next;

  logic [IW-1:0] in_r, in_c;
  logic          in_range;
  logic          scan_last, walk_last;

  assign in_r      = IW'(row_index);
  assign in_c      = IW'(col_index);
  assign in_range  = (int'(row_index) < MAX_ITEMS) && (int'(col_index) < MAX_ITEMS) &&
                     (row_index != col_index);
  assign scan_last = (i == IW'(MAX_ITEMS - 1)) && (j == i - IW'(1));
  assign walk_last = (i == IW'(MAX_ITEMS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_v     <= 1'b0;
      active     <= '0;
      count      <= '0;
      best_found <= 1'b0;
    end else begin
      state      <= state_next;
      pend_v     <= pend_v_next;
      active     <= active_next;
      count      <= count_next;
      best_found <= best_found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ri        <= in_r;
      ci        <= in_c;
      load_dist <= distance;
    end
    i      <= i_next;
    j      <= j_next;
    pend_a <= pend_a_next;
    pend_b <= pend_b_next;
    best_d <= best_d_next;
    best_i <= best_i_next;
    best_j <= best_j_next;
  end

  always_comb begin
    state_next      = state;
    i_next          = i;
    j_next          = j;
    pend_v_next     = 1'b0;
    pend_a_next     = pend_a;
    pend_b_next     = pend_b;
    best_found_next = best_found;
    best_d_next     = best_d;
    best_i_next     = best_i;
    best_j_next     = best_j;
    active_next     = active;
    count_next      = count;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    we              = 1'b0;
    waddr           = pair_addr(ri, ci);
    wdata           = load_dist;
    raddr_a         = pair_addr(i, j);
    raddr_b         = pair_addr(ci, i);

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          best_found_next = 1'b0;
          best_d_next     = '0;
          best_i_next     = '0;
          best_j_next     = '0;
          i_next          = '0;
          j_next          = '0;
          unique case (mode_t'(mode))
            MODE_LOAD: begin
              state_next = in_range ? ST_LOAD : ST_DONE;
            end
            MODE_FIND: begin
              i_next     = IW'(1);
              state_next = ST_SCAN;
            end
            MODE_MERGE: begin
              state_next = (in_range && active[in_r] && active[in_c]) ? ST_MERGE : ST_DONE;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_LOAD: begin
        we              = 1'b1;
        active_next[ri] = 1'b1;
        active_next[ci] = 1'b1;
        count_next      = count + COUNT_W'(!active[ri]) + COUNT_W'(!active[ci]);
        state_next      = ST_DONE;
      end
      ST_SCAN: begin
        pend_v_next = active[i] && active[j];
        pend_a_next = i;
        pend_b_next = j;
        if (j == i - IW'(1)) begin
          i_next = i + IW'(1);
          j_next = '0;
        end else begin
          j_next = j + IW'(1);
        end
        if (scan_last) begin
          state_next = ST_SCAN_DRAIN;
        end
      end
      ST_SCAN_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_MERGE: begin
        raddr_a     = pair_addr(ri, i);
        pend_v_next = active[i] && (i != ri) && (i != ci);
        pend_a_next = i;
        i_next      = i + IW'(1);
        if (walk_last) begin
          state_next = ST_MERGE_DRAIN;
        end
      end
      ST_MERGE_DRAIN: begin
        active_next[ci] = 1'b0;
        count_next      = count - COUNT_W'(1);
        state_next      = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Read data for the pair issued last cycle arrives now.
    if ((state == ST_SCAN || state == ST_SCAN_DRAIN) && pend_v &&
        (!best_found || rdata_a < best_d)) begin
      best_found_next = 1'b1;
      best_d_next     = rdata_a;
      best_i_next     = pend_a;
      best_j_next     = pend_b;
    end

    if ((state == ST_MERGE || state == ST_MERGE_DRAIN) && pend_v) begin
      we    = 1'b1;
      waddr = pair_addr(ri, pend_a);
      wdata = (rdata_a < rdata_b) ? rdata_a : rdata_b;
    end
  end

  always_comb begin
    res.found        = best_found;
    res.first_index  = IDX_W'(best_i);
    res.second_index = IDX_W'(best_j);
    res.min_distance = best_d;
    res.active_count = count;
  end

  a_count_matches_mask: assert property (@(posedge clk) disable iff (rst)
    int'(count) == $countones(active))
    else $error("active count differs from the number of active items");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_SCAN_DRAIN) |-> !we)
    else $error("distance store written during a find scan");

  a_scan_pair_active: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN || state == ST_SCAN_DRAIN) && pend_v) |->
      (active[pend_a] && active[pend_b]))
    else $error("scan compared a pair with an inactive item");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != ST_IDLE))
    else $error("sequencer stayed idle after an input transfer");

  a_drain_leads_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE_DRAIN) |=> (state == ST_DONE && !active[ci]))
    else $error("merge did not retire the removed cluster");

endmodule

/* src/single_linkage_merge_engine_top.sv */
// Top level of the single-linkage merge engine: sequencer, distance store and
// output register. Depends on slme_pkg, slme_ctrl and slme_dist_ram.
//
// channel  direction  handshake            payload
// input    in         in_valid / in_ready  mode, row_index, col_index, distance
// output   out        out_valid/ out_ready found, first_index, second_index,
//                                          min_distance, active_count
//
// One item at a time. A load writes its pair and then gives its result; a no-op, and a
// load or merge that changes nothing, go from idle straight to the result state.
// Find scans one stored pair a cycle through a read port of the distance store; merge
// walks one item a cycle with both read ports and a write-back in the following cycle.
// Reset clears the active mask, the count and the control state; the distance store
// is not cleared. The output register lets the next item be taken while a result
// waits; a result then stays in the sequencer until the output register frees.
module single_linkage_merge_engine_top #(
  parameter int MAX_ITEMS = slme_pkg::MAX_ITEMS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   mode,
  input  logic [slme_pkg::IDX_W-1:0]   row_index,
  input  logic [slme_pkg::IDX_W-1:0]   col_index,
  input  logic [slme_pkg::DIST_W-1:0]  distance,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [slme_pkg::IDX_W-1:0]   first_index,
  output logic [slme_pkg::IDX_W-1:0]   second_index,
  output logic [slme_pkg::DIST_W-1:0]  min_distance,
  output logic [slme_pkg::COUNT_W-1:0] active_count
);
  import slme_pkg::*;

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int AW = 2 * IW;

  logic              res_valid, res_ready;
  result_t           res, out_res;
  logic              we;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [DIST_W-1:0] wdata, rdata_a, rdata_b;

  slme_ctrl #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .row_index (row_index),
    .col_index (col_index),
    .distance  (distance),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b)
  );

  slme_dist_ram #(
    .AW(AW)
  ) u_dist_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign found        = out_res.found;
  assign first_index  = out_res.first_index;
  assign second_index = out_res.second_index;
  assign min_distance = out_res.min_distance;
  assign active_count = out_res.active_count;

endmodule

/* test/single_linkage_merge_engine_top_tb.sv */
// Self-checking testbench for single_linkage_merge_engine_top: builds clustering sessions of
// distance loads, minimum-pair finds and merges, and checks every result against its own model.
// Depends on slme_pkg and the RTL under src.
`timescale 1ns / 100ps

module single_linkage_merge_engine_top_tb;
  import slme_pkg::*;

  localparam int ITEM_COUNT = MAX_ITEMS_DEFAULT;
  localparam int SLOT_COUNT = ITEM_COUNT * ITEM_COUNT;
  localparam int TAIL_ITEMS = 40;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct {
    mode_t             op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DIST_W-1:0] load_dist;
  } engine_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           mode = '0;
  logic [IDX_W-1:0]     row_index = '0;
  logic [IDX_W-1:0]     col_index = '0;
  logic [DIST_W-1:0]    distance = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 found;
  logic [IDX_W-1:0]     first_index;
  logic [IDX_W-1:0]     second_index;
  logic [DIST_W-1:0]    min_distance;
  logic [COUNT_W-1:0]   active_count;

  engine_req_t pending_requests[$];
  result_t     expected_results[$];

  // Shadow used while building stimulus: which items are active and which pairs hold a value.
  bit [ITEM_COUNT-1:0] plan_active;
  bit                  plan_written [0:SLOT_COUNT-1];

  // State of the predictor.
  logic [DIST_W-1:0]   engine_dist [0:SLOT_COUNT-1];
  bit [ITEM_COUNT-1:0] engine_active;

  int  error_count = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  send_idle_pct = 20;
  int  recv_idle_pct = 20;
  int  sent_count = 0;
  int  recv_count = 0;
  bit  calm = 1'b0;

  single_linkage_merge_engine_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .row_index    (row_index),
    .col_index    (col_index),
    .distance     (distance),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .first_index  (first_index),
    .second_index (second_index),
    .min_distance (min_distance),
    .active_count (active_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int pair_slot(input int a, input int b);
    return (a > b) ? (a * ITEM_COUNT + b) : (b * ITEM_COUNT + a);
  endfunction

  function automatic result_t predict_step(input logic [1:0] op, input logic [IDX_W-1:0] r,
                                           input logic [IDX_W-1:0] c,
                                           input logic [DIST_W-1:0] d);
    result_t res;
    logic [DIST_W-1:0] a;
    logic [DIST_W-1:0] b;
    res = '0;
    case (mode_t'(op))
      MODE_LOAD: begin
        if (r != c) begin
          engine_dist[pair_slot(r, c)] = d;
          engine_active[r] = 1'b1;
          engine_active[c] = 1'b1;
        end
      end
      MODE_FIND: begin
        for (int i = 0; i < ITEM_COUNT; i++) begin
          for (int j = 0; j < i; j++) begin
            if (engine_active[i] && engine_active[j]) begin
              a = engine_dist[i * ITEM_COUNT + j];
              if (!res.found || a < res.min_distance) begin
                res.found = 1'b1;
                res.min_distance = a;
                res.first_index = IDX_W'(i);
                res.second_index = IDX_W'(j);
              end
            end
          end
        end
      end
      MODE_MERGE: begin
        if (r != c && engine_active[r] && engine_active[c]) begin
          for (int k = 0; k < ITEM_COUNT; k++) begin
            if (engine_active[k] && k != r && k != c) begin
              a = engine_dist[pair_slot(r, k)];
              b = engine_dist[pair_slot(c, k)];
              engine_dist[pair_slot(r, k)] = (a < b) ? a : b;
            end
          end
          engine_active[c] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res.active_count = COUNT_W'($countones(engine_active));
    return res;
  endfunction

  function automatic logic [DIST_W-1:0] rand_distance();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 5) return DIST_W'($urandom_range(0, 15));
    if (pick < 7) return DIST_MAX;
    if (pick < 8) return '0;
    return DIST_W'({$urandom, $urandom});
  endfunction

  function automatic int pick_item(input bit want_active);
    int x;
    x = $urandom_range(0, ITEM_COUNT - 1);
    while (plan_active[x] != want_active) x = $urandom_range(0, ITEM_COUNT - 1);
    return x;
  endfunction

  function automatic void push_request(input mode_t op, input int r, input int c,
                                       input logic [DIST_W-1:0] d);
    engine_req_t req;
    req.op = op;
    req.row = IDX_W'(r);
    req.col = IDX_W'(c);
    req.load_dist = d;
    pending_requests.push_back(req);
    if (op == MODE_LOAD && r != c) begin
      plan_written[pair_slot(r, c)] = 1'b1;
      plan_active[r] = 1'b1;
      plan_active[c] = 1'b1;
    end else if (op == MODE_MERGE && r != c && plan_active[r] && plan_active[c]) begin
      plan_active[c] = 1'b0;
    end
  endfunction

  function automatic void push_load(input int a, input int b, input logic [DIST_W-1:0] d);
    if ($urandom_range(0, 1)) push_request(MODE_LOAD, a, b, d);
    else push_request(MODE_LOAD, b, a, d);
  endfunction

  function automatic void push_merge_pair();
    int r;
    int c;
    r = pick_item(1'b1);
    c = pick_item(1'b1);
    while (c == r) c = pick_item(1'b1);
    push_request(MODE_MERGE, r, c, rand_distance());
  endfunction

  // Items that leave every active pair written: no-ops, equal-index loads, merges that do
  // nothing, overwrites of pairs between active items, and finds while under two are active.
  function automatic void push_noise();
    int r;
    case ($urandom_range(0, 4))
      0: push_request(MODE_NOP, $urandom_range(0, 63), $urandom_range(0, 63), rand_distance());
      1: begin
        r = $urandom_range(0, 63);
        push_request(MODE_LOAD, r, r, rand_distance());
      end
      2: begin
        r = $urandom_range(0, 63);
        push_request(MODE_MERGE, r, r, rand_distance());
      end
      3: begin
        if ($urandom_range(0, 1)) push_request(MODE_MERGE, $urandom_range(0, 63),
                                               pick_item(1'b0), rand_distance());
        else push_request(MODE_MERGE, pick_item(1'b0), $urandom_range(0, 63),
                          rand_distance());
      end
      default: begin
        if ($countones(plan_active) >= 2) begin
          r = pick_item(1'b1);
          push_load(r, pick_item(1'b1) == r ? r : pick_item(1'b1), rand_distance());
        end else begin
          push_request(MODE_FIND, $urandom_range(0, 63), $urandom_range(0, 63),
                       rand_distance());
        end
      end
    endcase
  endfunction

  // One clustering session: add items with the distances they need, then find and merge.
  function automatic void push_session();
    int n_new;
    int x;
    int steps;
    bit [ITEM_COUNT-1:0] chosen;
    chosen = '0;
    if ($countones(plan_active) <= 3 && $urandom_range(0, 5) == 0) n_new = $urandom_range(5, 8);
    else n_new = $urandom_range(1, 4);
    for (int n = 0; n < n_new; n++) begin
      x = pick_item(1'b0);
      while (chosen[x]) x = pick_item(1'b0);
      chosen[x] = 1'b1;
      for (int y = 0; y < ITEM_COUNT; y++) begin
        if (plan_active[y] && y != x &&
            (!plan_written[pair_slot(x, y)] || $urandom_range(0, 2) == 0)) begin
          push_load(x, y, rand_distance());
        end
      end
      if (!plan_active[x]) push_load(x, pick_item(1'b1), rand_distance());
      if ($urandom_range(0, 5) == 0) push_noise();
    end
    steps = $urandom_range(1, 4);
    for (int s = 0; s < steps || $countones(plan_active) > 6; s++) begin
      push_request(MODE_FIND, $urandom_range(0, 63), $urandom_range(0, 63), rand_distance());
      if ($countones(plan_active) >= 2 && $urandom_range(0, 3) != 0) push_merge_pair();
      if ($urandom_range(0, 3) == 0) push_noise();
    end
  endfunction

  task automatic compare_field(input string field_name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
      error_count++;
    end
  endtask

  initial begin
    plan_active = '0;
    engine_active = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      plan_written[i] = 1'b0;
      engine_dist[i] = '0;
    end

    push_request(MODE_FIND, 0, 0, '0);
    push_request(MODE_MERGE, 3, 4, rand_distance());
    push_request(MODE_NOP, 63, 63, DIST_MAX);
    push_request(MODE_LOAD, 7, 7, DIST_W'(5));
    push_request(MODE_LOAD, 63, 0, DIST_MAX);
    push_request(MODE_LOAD, 0, 62, DIST_MAX);
    push_request(MODE_LOAD, 63, 62, '0);
    push_request(MODE_FIND, 21, 42, DIST_MAX);
    push_request(MODE_LOAD, 62, 63, DIST_MAX);
    push_request(MODE_FIND, 0, 0, '0);
    push_request(MODE_MERGE, 63, 63, '0);
    push_request(MODE_MERGE, 63, 5, '0);
    push_request(MODE_MERGE, 5, 63, '0);
    push_request(MODE_LOAD, 63, 62, DIST_W'(3));
    push_request(MODE_MERGE, 0, 63, '0);
    push_request(MODE_FIND, 0, 0, '0);
    push_request(MODE_MERGE, 62, 0, '0);
    push_request(MODE_FIND, 0, 0, '0);
    push_request(MODE_MERGE, 62, 0, '0);
    push_request(MODE_LOAD, 63, 62, DIST_W'(42));
    push_request(MODE_LOAD, 63, 0, DIST_W'(9));
    push_request(MODE_FIND, 0, 0, '0);
    push_request(MODE_MERGE, 63, 62, '0);
    push_request(MODE_FIND, 0, 0, '0);

    while (pending_requests.size() < 225) push_session();

    // Bring every item in; no find or merge may follow since most pairs stay unwritten.
    for (int i = 0; i < ITEM_COUNT; i++) begin
      if (!plan_active[i]) push_load(i, (i == 0) ? 1 : 0, rand_distance());
    end
    push_request(MODE_LOAD, 17, 17, rand_distance());
    push_request(MODE_NOP, 0, 0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk) begin
    engine_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      calm <= (pending_requests.size() <= TAIL_ITEMS);
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_step(mode, row_index, col_index, distance));
        sent_count <= sent_count + 1;
        if (sent_count % 32 == 0) send_idle_pct <= 15 * $urandom_range(0, 2);
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0 && !calm &&
                     $urandom_range(0, 99) < send_idle_pct) begin
          send_gap <= $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          req = pending_requests.pop_front();
          mode <= req.op;
          row_index <= req.row;
          col_index <= req.col;
          distance <= req.load_dist;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want_res;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result transfer with no expected result, expected none, actual %0h",
                   $time, {found, first_index, second_index, min_distance, active_count});
          error_count++;
        end else begin
          want_res = expected_results.pop_front();
          compare_field("found", 64'(want_res.found), 64'(found));
          compare_field("first_index", 64'(want_res.first_index), 64'(first_index));
          compare_field("second_index", 64'(want_res.second_index), 64'(second_index));
          compare_field("min_distance", 64'(want_res.min_distance), 64'(min_distance));
          compare_field("active_count", 64'(want_res.active_count), 64'(active_count));
        end
        recv_count <= recv_count + 1;
        if (recv_count % 32 == 0) recv_idle_pct <= 15 * $urandom_range(0, 2);
      end
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap <= $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
